>>> design/flc_pkg.sv
package flc_pkg;

    typedef struct packed {
        logic               opcode;
        logic               key_forward;
        logic               key_back;
        logic               key_left;
        logic               key_right;
        logic [23:0]        delta_time;
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_out_item;

    localparam logic [1:0] CFG_MOVE_SPEED  = 2'd0;
    localparam logic [1:0] CFG_MOUSE_SENS  = 2'd1;

    localparam logic [15:0] SPEED_RESET = 16'd3277;
    localparam logic [15:0] SENS_RESET  = 16'd1638;

    localparam logic signed [32:0] DEG_89      = 33'sd5832704;
    localparam logic signed [27:0] DEG_90      = 28'sd5898240;
    localparam logic signed [27:0] DEG_180     = 28'sd11796480;
    localparam logic signed [34:0] DEG_180_W   = 35'sd11796480;
    localparam logic signed [34:0] DEG_360_W   = 35'sd23592960;
    localparam logic signed [34:0] DEG_360_X256 = 35'sd6039797760;
    localparam logic signed [25:0] YAW_RESET   = -26'sd5898240;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [15:0] UNIT_Q14    = 16'sd16384;
    localparam logic signed [31:0] POS_Y_RESET = 32'sd98304;
    localparam logic signed [31:0] POS_Z_RESET = -32'sd65536;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCALE,
        OP_ANG,
        OP_WRAP,
        OP_YAW,
        OP_CLOAD,
        OP_CITER,
        OP_CSTORE,
        OP_MUL,
        OP_MLO,
        OP_MHI,
        OP_MADD,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic       load;
        t_op        op;
        logic [3:0] idx;
        logic       sel;
        logic [1:0] move;
    } t_cmd;

    typedef struct packed {
        logic       opcode;
        logic [3:0] keys;
        logic       out_free;
    } t_stat;

    // arctangent of 2^-i in Q.16 degrees
    function automatic logic [21:0] atan_deg(input logic [3:0] i);
        logic [21:0] r;
        case (i)
            4'd0:    r = 22'd2949120;
            4'd1:    r = 22'd1740967;
            4'd2:    r = 22'd919879;
            4'd3:    r = 22'd466945;
            4'd4:    r = 22'd234379;
            4'd5:    r = 22'd117303;
            4'd6:    r = 22'd58666;
            4'd7:    r = 22'd29335;
            4'd8:    r = 22'd14668;
            4'd9:    r = 22'd7334;
            4'd10:   r = 22'd3667;
            4'd11:   r = 22'd1833;
            4'd12:   r = 22'd917;
            4'd13:   r = 22'd458;
            4'd14:   r = 22'd229;
            default: r = 22'd115;
        endcase
        return r;
    endfunction

endpackage

>>> design/flc_ctrl.sv
module flc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  flc_pkg::t_stat i_stat,
    output flc_pkg::t_cmd  o_cmd
);
    import flc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_ANG, S_WRAP, S_YAW, S_CLOAD, S_CITER, S_CSTORE,
        S_MUL, S_MSEL, S_MLO, S_MHI, S_MADD, S_OUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic       r_sel;
    logic [2:0] r_move;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.load = i_in_valid && (r_state == S_IDLE);
        o_cmd.idx  = r_cnt;
        o_cmd.sel  = r_sel;
        o_cmd.move = r_move[1:0];
        unique case (r_state)
            S_SCALE:  o_cmd.op = OP_SCALE;
            S_ANG:    o_cmd.op = OP_ANG;
            S_WRAP:   o_cmd.op = OP_WRAP;
            S_YAW:    o_cmd.op = OP_YAW;
            S_CLOAD:  o_cmd.op = OP_CLOAD;
            S_CITER:  o_cmd.op = OP_CITER;
            S_CSTORE: o_cmd.op = OP_CSTORE;
            S_MUL:    o_cmd.op = OP_MUL;
            S_MLO:    o_cmd.op = OP_MLO;
            S_MHI:    o_cmd.op = OP_MHI;
            S_MADD:   o_cmd.op = OP_MADD;
            S_OUT:    o_cmd.op = i_stat.out_free ? OP_OUT : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
            r_move  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_move <= '0;
                    r_state <= i_stat.opcode ? S_ANG : S_MSEL;
                end
                S_ANG: begin
                    r_cnt   <= 4'd7;
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    if (r_cnt == 4'd0) r_state <= S_YAW;
                    else r_cnt <= r_cnt - 4'd1;
                end
                S_YAW: begin
                    r_sel   <= 1'b0;
                    r_state <= S_CLOAD;
                end
                S_CLOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_CITER;
                end
                S_CITER: begin
                    if (r_cnt == 4'd15) r_state <= S_CSTORE;
                    else r_cnt <= r_cnt + 4'd1;
                end
                S_CSTORE: begin
                    r_cnt <= '0;
                    if (!r_sel) begin
                        r_sel   <= 1'b1;
                        r_state <= S_CLOAD;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == 4'd3) r_state <= S_OUT;
                    else r_cnt <= r_cnt + 4'd1;
                end
                S_MSEL: begin
                    r_cnt <= '0;
                    if (r_move[2]) r_state <= S_OUT;
                    else if (i_stat.keys[r_move[1:0]]) r_state <= S_MLO;
                    else r_move <= r_move + 3'd1;
                end
                S_MLO:  r_state <= S_MHI;
                S_MHI:  r_state <= S_MADD;
                S_MADD: begin
                    if (r_cnt == 4'd2) begin
                        r_move  <= r_move + 3'd1;
                        r_state <= S_MSEL;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= S_MLO;
                    end
                end
                S_OUT: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/flc_dp.sv
module flc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  flc_pkg::t_cmd      i_cmd,
    input  flc_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output flc_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output flc_pkg::t_out_item o_out_data
);
    import flc_pkg::*;

    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [17:0] r;
        t = 34'(v) + 34'sd32768;
        r = 18'(t >>> 16);
        if (r > 18'sd16384) r = 18'sd16384;
        if (r < -18'sd16384) r = -18'sd16384;
        return 16'(r);
    endfunction

    logic [15:0]        r_speed, r_sens;
    t_in_item           r_item;
    logic signed [31:0] r_dx, r_dy;
    logic [39:0]        r_step;
    logic signed [25:0] r_yaw;
    logic signed [23:0] r_pitch;
    logic signed [34:0] r_w;
    logic signed [32:0] r_x, r_y;
    logic signed [27:0] r_z;
    logic               r_flip;
    logic signed [15:0] r_sy, r_cy, r_sp, r_cp;
    logic signed [31:0] r_pos   [3];
    logic signed [15:0] r_front [3];
    logic signed [15:0] r_right [3];
    logic signed [15:0] r_up    [3];
    logic signed [56:0] r_acc;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [32:0] w_dx, w_dy, w_pt;
    logic [39:0]        w_step;
    logic signed [34:0] w_v, w_wrapk;
    logic signed [27:0] w_ang, w_at;
    logic signed [32:0] w_xs, w_ys, w_sv, w_cv;
    logic signed [15:0] w_ma, w_mb, w_mr, w_vec;
    logic signed [31:0] w_mp;
    logic signed [36:0] w_plo, w_phi;
    logic signed [33:0] w_d, w_p;
    logic signed [31:0] w_psat, w_pos;
    logic [1:0]         w_k;

    assign w_k    = (i_cmd.idx[1:0] == 2'd3) ? 2'd2 : i_cmd.idx[1:0];
    assign w_dx   = r_item.x_offset * $signed({1'b0, r_sens});
    assign w_dy   = r_item.y_offset * $signed({1'b0, r_sens});
    assign w_step = r_speed * r_item.delta_time;
    assign w_pt   = 33'(r_pitch) + 33'(r_dy);
    assign w_v    = 35'(r_yaw) + 35'(r_dx) + DEG_180_W;
    assign w_wrapk = DEG_360_W <<< i_cmd.idx[2:0];
    assign w_ang  = i_cmd.sel ? 28'(r_pitch) : 28'(r_yaw);
    assign w_at   = $signed({6'd0, atan_deg(i_cmd.idx)});
    assign w_xs   = r_x >>> i_cmd.idx;
    assign w_ys   = r_y >>> i_cmd.idx;
    assign w_sv   = r_flip ? -r_y : r_y;
    assign w_cv   = r_flip ? -r_x : r_x;

    always_comb begin
        case (i_cmd.idx[1:0])
            2'd0:    begin w_ma = r_cy; w_mb = r_cp; end
            2'd1:    begin w_ma = r_sy; w_mb = r_cp; end
            2'd2:    begin w_ma = r_cy; w_mb = r_sp; end
            default: begin w_ma = r_sy; w_mb = r_sp; end
        endcase
    end
    assign w_mp = 32'(w_ma) * 32'(w_mb) + 32'sd8192;
    assign w_mr = 16'(w_mp >>> 14);

    // movement: front for forward/back, right for strafing
    assign w_vec = i_cmd.move[1] ? r_right[w_k] : r_front[w_k];
    assign w_plo = w_vec * $signed({1'b0, r_step[19:0]});
    assign w_phi = w_vec * $signed({1'b0, r_step[39:20]});
    assign w_d   = 34'((r_acc + 57'sd536870912) >>> 30);
    assign w_pos = r_pos[w_k];
    assign w_p   = (i_cmd.move == 2'd1 || i_cmd.move == 2'd2) ?
                   34'(w_pos) - w_d : 34'(w_pos) + w_d;
    always_comb begin
        if (w_p > 34'sd2147483647) w_psat = 32'sh7fffffff;
        else if (w_p < -34'sd2147483648) w_psat = 32'sh80000000;
        else w_psat = 32'(w_p);
    end

    // control and camera state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= SPEED_RESET;
            r_sens      <= SENS_RESET;
            r_yaw       <= YAW_RESET;
            r_pitch     <= '0;
            r_pos[0]    <= '0;
            r_pos[1]    <= POS_Y_RESET;
            r_pos[2]    <= POS_Z_RESET;
            r_front[0]  <= '0;
            r_front[1]  <= '0;
            r_front[2]  <= -UNIT_Q14;
            r_right[0]  <= UNIT_Q14;
            r_right[1]  <= '0;
            r_right[2]  <= '0;
            r_up[0]     <= '0;
            r_up[1]     <= UNIT_Q14;
            r_up[2]     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MOVE_SPEED: r_speed <= i_cfg_data;
                    CFG_MOUSE_SENS: r_sens  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_ANG: begin
                    if (w_pt > DEG_89) r_pitch <= 24'(DEG_89);
                    else if (w_pt < -DEG_89) r_pitch <= 24'(-DEG_89);
                    else r_pitch <= 24'(w_pt);
                end
                OP_YAW: r_yaw <= 26'(r_w - DEG_180_W);
                OP_MUL: begin
                    case (i_cmd.idx[1:0])
                        2'd0: begin
                            r_front[0] <= w_mr;
                            r_front[1] <= r_sp;
                            r_up[1]    <= r_cp;
                            r_right[0] <= -r_sy;
                            r_right[1] <= '0;
                            r_right[2] <= r_cy;
                        end
                        2'd1:    r_front[2] <= w_mr;
                        2'd2:    r_up[0]    <= -w_mr;
                        default: r_up[2]    <= -w_mr;
                    endcase
                end
                OP_MADD: r_pos[w_k] <= w_psat;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_data;
        case (i_cmd.op)
            OP_SCALE: begin
                r_dx   <= 32'(w_dx);
                r_dy   <= 32'(w_dy);
                r_step <= w_step;
            end
            OP_ANG:  r_w <= (w_v < 0) ? w_v + DEG_360_X256 : w_v;
            OP_WRAP: if (r_w >= w_wrapk) r_w <= r_w - w_wrapk;
            OP_CLOAD: begin
                r_x <= CORDIC_GAIN;
                r_y <= '0;
                if (w_ang > DEG_90) begin
                    r_z <= w_ang - DEG_180;
                    r_flip <= 1'b1;
                end else if (w_ang < -DEG_90) begin
                    r_z <= w_ang + DEG_180;
                    r_flip <= 1'b1;
                end else begin
                    r_z <= w_ang;
                    r_flip <= 1'b0;
                end
            end
            OP_CITER: begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
            end
            OP_CSTORE: begin
                if (i_cmd.sel) begin
                    r_sp <= to_q14(w_sv);
                    r_cp <= to_q14(w_cv);
                end else begin
                    r_sy <= to_q14(w_sv);
                    r_cy <= to_q14(w_cv);
                end
            end
            OP_MLO: r_acc <= 57'(w_plo);
            OP_MHI: r_acc <= r_acc + (57'(w_phi) <<< 20);
            OP_OUT: begin
                r_out.pos_x   <= r_pos[0];
                r_out.pos_y   <= r_pos[1];
                r_out.pos_z   <= r_pos[2];
                r_out.front_x <= r_front[0];
                r_out.front_y <= r_front[1];
                r_out.front_z <= r_front[2];
                r_out.up_x    <= r_up[0];
                r_out.up_y    <= r_up[1];
                r_out.up_z    <= r_up[2];
            end
            default: ;
        endcase
    end

    assign o_stat.opcode   = r_item.opcode;
    assign o_stat.keys     = {r_item.key_right, r_item.key_left,
                              r_item.key_back, r_item.key_forward};
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (33'(r_pitch) <= DEG_89) && (33'(r_pitch) >= -DEG_89))
        else $error("pitch outside clamp range");
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (28'(r_yaw) < DEG_180) && (28'(r_yaw) >= -DEG_180))
        else $error("yaw outside wrap range");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == OP_OUT))
        else $error("result raised without output command");

endmodule

>>> design/free_look_camera_update_unit.sv
// Free-look camera update. Each input request yields one result with the
// position and the front and up vectors after that request. In a mouse
// request eight restoring steps wrap the yaw, then one shared 16-step
// CORDIC runs for yaw and for pitch, and one multiplier forms the four
// vector products. In a tick request each key held moves three position
// components, each through two partial products and one saturating add.
// A new request is accepted only after the result of the last one has been
// issued. The config port is always ready.
module free_look_camera_update_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  flc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output flc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import flc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    flc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    flc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/free_look_camera_update_unit_tb.sv
module free_look_camera_update_unit_tb;
    import flc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = CFG_MOVE_SPEED;
    logic [15:0] cfg_data = '0;

    free_look_camera_update_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // camera model state
    longint    cam_speed, cam_sens, cam_yaw, cam_pitch;
    longint    cam_pos[3], cam_front[3], cam_right[3], cam_up[3];
    t_out_item pending_views[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int n_items = 0, n_mouse = 0, n_ticks = 0, n_results = 0;
    int quiet_cycles = 0;

    function automatic longint q14_round(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic longint mul_q14(longint a, longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
        longint x, y, z, nx;
        bit flip;
        x = 652032874;
        y = 0;
        z = ang;
        flip = 0;
        if (z > 5898240) begin
            z -= 11796480;
            flip = 1;
        end else if (z < -5898240) begin
            z += 11796480;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(atan_deg(i[3:0]));
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(atan_deg(i[3:0]));
            end
            x = nx;
        end
        s = q14_round(flip ? -y : y);
        c = q14_round(flip ? -x : x);
    endtask

    task automatic camera_reset();
        cam_speed = SPEED_RESET;
        cam_sens = SENS_RESET;
        cam_yaw = -5898240;
        cam_pitch = 0;
        cam_pos = '{0, 98304, -65536};
        cam_front = '{0, 0, -16384};
        cam_right = '{16384, 0, 0};
        cam_up = '{0, 16384, 0};
    endtask

    task automatic move_camera(input longint vec[3], input longint step, input bit add);
        longint d, p;
        for (int k = 0; k < 3; k++) begin
            d = (step * vec[k] + (longint'(1) << 29)) >>> 30;
            p = add ? cam_pos[k] + d : cam_pos[k] - d;
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            cam_pos[k] = p;
        end
    endtask

    function automatic t_out_item camera_view();
        t_out_item v;
        v.pos_x = cam_pos[0][31:0];
        v.pos_y = cam_pos[1][31:0];
        v.pos_z = cam_pos[2][31:0];
        v.front_x = cam_front[0][15:0];
        v.front_y = cam_front[1][15:0];
        v.front_z = cam_front[2][15:0];
        v.up_x = cam_up[0][15:0];
        v.up_y = cam_up[1][15:0];
        v.up_z = cam_up[2][15:0];
        return v;
    endfunction

    task automatic advance_camera(input t_in_item it);
        longint yw, pt, sy, cy, sp, cp, step;
        if (it.opcode) begin
            yw = (cam_yaw + longint'(it.x_offset) * cam_sens) % 23592960;
            pt = cam_pitch + longint'(it.y_offset) * cam_sens;
            if (yw < 0) yw += 23592960;
            if (yw >= 11796480) yw -= 23592960;
            if (pt > 5832704) pt = 5832704;
            if (pt < -5832704) pt = -5832704;
            cam_yaw = yw;
            cam_pitch = pt;
            cordic_sin_cos(cam_yaw, sy, cy);
            cordic_sin_cos(cam_pitch, sp, cp);
            cam_front = '{mul_q14(cy, cp), sp, mul_q14(sy, cp)};
            cam_right = '{-sy, 0, cy};
            cam_up = '{-mul_q14(cy, sp), cp, -mul_q14(sy, sp)};
            n_mouse++;
        end else begin
            step = cam_speed * longint'(it.delta_time);
            if (it.key_forward) move_camera(cam_front, step, 1);
            if (it.key_back) move_camera(cam_front, step, 0);
            if (it.key_left) move_camera(cam_right, step, 0);
            if (it.key_right) move_camera(cam_right, step, 1);
            n_ticks++;
        end
        pending_views.push_back(camera_view());
    endtask

    task automatic send_request(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        advance_camera(it);
        n_items++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MOVE_SPEED) cam_speed = val;
        else if (idx == CFG_MOUSE_SENS) cam_sens = val;
        @(posedge i_clk);
    endtask

    function automatic t_in_item tick_item(bit f, bit b, bit l, bit r, logic [23:0] dt);
        t_in_item it;
        it = '0;
        it.opcode = 1'b0;
        {it.key_forward, it.key_back, it.key_left, it.key_right} = {f, b, l, r};
        it.delta_time = dt;
        it.x_offset = 16'($urandom);
        it.y_offset = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item mouse_item(logic [15:0] xo, logic [15:0] yo);
        t_in_item it;
        it = t_in_item'(61'({$urandom, $urandom}));
        it.opcode = 1'b1;
        it.x_offset = xo;
        it.y_offset = yo;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it = t_in_item'(61'({$urandom, $urandom}));
        // mostly short frame times, sometimes the full range
        if (!it.opcode && $urandom_range(3) != 0) it.delta_time = 24'($urandom_range(4000));
        if (it.opcode && $urandom_range(1) == 0) begin
            it.x_offset = 16'($signed($urandom_range(400)) - 200);
            it.y_offset = 16'($signed($urandom_range(400)) - 200);
        end
        return it;
    endfunction

    task automatic test_directed();
        send_request(tick_item(0, 0, 0, 0, 24'hFFFFFF));
        send_request(tick_item(1, 0, 0, 0, 24'h010000));
        send_request(tick_item(0, 1, 0, 0, 24'hFFFFFF));
        send_request(tick_item(0, 0, 1, 0, 24'h008000));
        send_request(tick_item(0, 0, 0, 1, 24'h000000));
        send_request(tick_item(1, 1, 1, 1, 24'h123456));
        send_request(mouse_item(16'sh7FFF, 16'sh7FFF));
        send_request(mouse_item(16'sh8000, 16'sh8000));
        send_request(mouse_item(16'sh8000, 16'sh8000));
        send_request(mouse_item(16'h0000, 16'h0000));
        send_request(mouse_item(16'sh7FFF, 16'sh0001));
        send_request(mouse_item(16'shFFFF, 16'sh7FFF));
        send_request(tick_item(1, 1, 0, 0, 24'hFFFFFF));
        send_request(tick_item(0, 0, 1, 1, 24'hFFFFFF));
        send_request(tick_item(1, 0, 0, 1, 24'h0000FF));
    endtask

    task automatic test_registers();
        write_reg(CFG_MOVE_SPEED, 16'hFFFF);
        write_reg(CFG_MOUSE_SENS, 16'hFFFF);
        write_reg(2'd2, 16'h1234);
        write_reg(2'd3, 16'hFFFF);
        send_request(mouse_item(16'sh0100, 16'sh8000));
        send_request(tick_item(1, 0, 1, 0, 24'hFFFFFF));
        write_reg(CFG_MOVE_SPEED, 16'h0000);
        write_reg(CFG_MOUSE_SENS, 16'h0000);
        send_request(mouse_item(16'sh7FFF, 16'sh7FFF));
        send_request(tick_item(1, 1, 1, 1, 24'hFFFFFF));
    endtask

    // full-speed moves until the position hits its limits
    task automatic test_saturation();
        write_reg(CFG_MOVE_SPEED, 16'hFFFF);
        write_reg(CFG_MOUSE_SENS, 16'h1000);
        send_request(mouse_item(16'sh01C2, 16'sh0590));
        for (int i = 0; i < 140; i++) send_request(tick_item(1, 0, 0, 1, 24'hFFFFFF));
        send_request(tick_item(1, 1, 0, 0, 24'hFFFFFF));
        for (int i = 0; i < 140; i++) send_request(tick_item(0, 1, 1, 0, 24'hFFFFFF));
        send_request(tick_item(0, 1, 1, 1, 24'hFFFFFF));
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) send_request(random_item());
        wait_drained();
        for (int i = 0; i < 10; i++) send_request(random_item());
    endtask

    task automatic test_random(input int count);
        logic [15:0] speeds[3];
        logic [15:0] senses[3];
        speeds = '{16'h0000, 16'hFFFF, 16'($urandom)};
        senses = '{16'hFFFF, 16'h0000, 16'($urandom)};
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 45 : 0;
            recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 7 : 0;
            write_reg(CFG_MOVE_SPEED, speeds[ph]);
            write_reg(CFG_MOUSE_SENS, senses[ph]);
            for (int i = 0; i < count; i++) begin
                send_request(random_item());
                if ($urandom_range(99) == 0) stop_sending();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t mismatch %s: expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            n_results++;
            if (pending_views.size() == 0) begin
                errors++;
                $display("%0t unexpected result, got %h", $time, out_data);
            end else begin
                want = pending_views.pop_front();
                check_field("pos_x", want.pos_x, out_data.pos_x);
                check_field("pos_y", want.pos_y, out_data.pos_y);
                check_field("pos_z", want.pos_z, out_data.pos_z);
                check_field("front_x", want.front_x, out_data.front_x);
                check_field("front_y", want.front_y, out_data.front_y);
                check_field("front_z", want.front_z, out_data.front_z);
                check_field("up_x", want.up_x, out_data.up_x);
                check_field("up_y", want.up_y, out_data.up_y);
                check_field("up_z", want.up_z, out_data.up_z);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_views.size());
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        camera_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_registers();
        test_saturation();
        test_backpressure();
        test_random(230);
        wait_drained();
        if (pending_views.size() != 0) errors++;
        $display("covered %0d requests (%0d mouse, %0d tick), %0d results checked,",
                 n_items, n_mouse, n_ticks, n_results);
        $display("register extremes, position limits and long output stalls; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
